// ===== src/bdpd_pkg.sv =====
// Package for the button debounce / press detector.
// Holds event codes, register indexes, reset values and the event bundle type.
package bdpd_pkg;

  localparam int unsigned MaxEvents = 4;
  localparam int unsigned FifoDepth = 2;

  typedef enum logic [2:0] {
    EV_DOWN        = 3'd0,
    EV_UP          = 3'd1,
    EV_UP_HOLD     = 3'd2,
    EV_DOWN_HOLD   = 3'd3,
    EV_LONG_PRESS  = 3'd4,
    EV_PRESS_COUNT = 3'd5
  } evt_kind_e;

  typedef enum logic [1:0] {
    CFG_ACTIVE_HIGH   = 2'd0,
    CFG_REPEAT_TICKS  = 2'd1,
    CFG_LONG_TICKS    = 2'd2,
    CFG_INITIAL_LEVEL = 2'd3
  } cfg_idx_e;

  localparam logic        ActiveHighRst   = 1'b0;
  localparam logic [15:0] RepeatTicksRst  = 16'd50;
  localparam logic [15:0] LongTicksRst    = 16'd0;
  localparam logic        InitialLevelRst = 1'b0;

  // events caused by one tick, in order
  typedef struct packed {
    logic [2:0]                    num;
    evt_kind_e [MaxEvents-1:0]     kind;
    logic [7:0]                    total;
  } bundle_t;

endpackage

// ===== src/bdpd_if.sv =====
// Valid/ready channel interfaces for the press detector.
// Depends on nothing.
interface bdpd_tick_if;
  logic valid;
  logic ready;
  logic pin_level;
  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

interface bdpd_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] press_total;
  logic       last_event;
  modport source (output valid, output event_kind, output press_total, output last_event,
                  input ready);
  modport sink (input valid, input event_kind, input press_total, input last_event,
                output ready);
endinterface

// ===== src/bdpd_front.sv =====
// Front end: config registers, timers, debouncer; classifies each tick into an
// event bundle. Depends on bdpd_pkg.
module bdpd_front #(
  parameter int unsigned DEBOUNCE_LIMIT = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              tick_valid_i,
  input  logic              pin_level_i,
  input  logic              full_i,
  output logic              tick_ready_o,
  output logic              push_o,
  output bdpd_pkg::bundle_t bundle_o
);

  localparam int unsigned LvlW = $clog2(DEBOUNCE_LIMIT + 1);
  localparam logic [LvlW-1:0] LvlMax = LvlW'(DEBOUNCE_LIMIT);

  logic        active_high_q;
  logic [15:0] repeat_ticks_q;
  logic [15:0] long_ticks_q;
  logic        stable_q, stable_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic [7:0]  tally_q, tally_d;
  logic [15:0] rep_q, rep_d;
  logic [15:0] long_q, long_d;
  logic        accept;
  bdpd_pkg::bundle_t bnd;

  assign tick_ready_o = !full_i && !cfg_we_i;
  assign accept       = tick_valid_i && tick_ready_o;

  always_comb begin
    logic change;
    stable_d = stable_q;
    lvl_d    = lvl_q;
    tally_d  = tally_q;
    rep_d    = rep_q;
    long_d   = long_q;
    change   = 1'b0;
    bnd.num   = '0;
    bnd.kind  = {bdpd_pkg::MaxEvents{bdpd_pkg::EV_DOWN}};
    bnd.total = '0;

    if (long_q != '0) begin
      long_d = long_q - 16'd1;
      if (long_d == '0) begin
        bnd.kind[bnd.num[1:0]] = bdpd_pkg::EV_LONG_PRESS;
        bnd.num = bnd.num + 3'd1;
        tally_d = '0;
      end
    end
    if (rep_q != '0) begin
      rep_d = rep_q - 16'd1;
      if (rep_d == '0) begin
        if (stable_q == active_high_q) begin
          bnd.kind[bnd.num[1:0]] = bdpd_pkg::EV_DOWN_HOLD;
        end else begin
          bnd.kind[bnd.num[1:0]] = bdpd_pkg::EV_PRESS_COUNT;
          bnd.total = tally_d;
        end
        bnd.num = bnd.num + 3'd1;
        tally_d = '0;
      end
    end

    if (pin_level_i) begin
      if (lvl_q < LvlMax) lvl_d = lvl_q + LvlW'(1);
      if (lvl_d == LvlMax && !stable_q) begin
        stable_d = 1'b1;
        change   = 1'b1;
      end
    end else begin
      if (lvl_q != '0) lvl_d = lvl_q - LvlW'(1);
      if (lvl_d == '0 && stable_q) begin
        stable_d = 1'b0;
        change   = 1'b1;
      end
    end

    if (change) begin
      if (stable_d == active_high_q) begin
        bnd.kind[bnd.num[1:0]] = bdpd_pkg::EV_DOWN;
        bnd.num = bnd.num + 3'd1;
        tally_d = tally_d + 8'd1;
        rep_d   = (repeat_ticks_q != '0) ? repeat_ticks_q : 16'd1;
        if (long_ticks_q != '0 && tally_d == 8'd1) long_d = long_ticks_q;
      end else begin
        bnd.kind[bnd.num[1:0]] = bdpd_pkg::EV_UP;
        bnd.num = bnd.num + 3'd1;
        long_d  = '0;
        if (rep_d == '0) begin
          bnd.kind[bnd.num[1:0]] = bdpd_pkg::EV_UP_HOLD;
          bnd.num = bnd.num + 3'd1;
        end
      end
    end
  end

  assign push_o   = accept && (bnd.num != '0);
  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_high_q  <= bdpd_pkg::ActiveHighRst;
      repeat_ticks_q <= bdpd_pkg::RepeatTicksRst;
      long_ticks_q   <= bdpd_pkg::LongTicksRst;
      stable_q       <= bdpd_pkg::InitialLevelRst;
      lvl_q          <= '0;
      tally_q        <= '0;
      rep_q          <= '0;
      long_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (bdpd_pkg::cfg_idx_e'(cfg_idx_i))
        bdpd_pkg::CFG_ACTIVE_HIGH:   active_high_q  <= cfg_data_i[0];
        bdpd_pkg::CFG_REPEAT_TICKS:  repeat_ticks_q <= cfg_data_i;
        bdpd_pkg::CFG_LONG_TICKS:    long_ticks_q   <= cfg_data_i;
        bdpd_pkg::CFG_INITIAL_LEVEL: stable_q       <= cfg_data_i[0];
        default: ;
      endcase
    end else if (accept) begin
      stable_q <= stable_d;
      lvl_q    <= lvl_d;
      tally_q  <= tally_d;
      rep_q    <= rep_d;
      long_q   <= long_d;
    end
  end

  a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni) lvl_q <= LvlMax)
    else $error("debounce level out of range");
  a_bundle_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> bnd.num <= 3'(bdpd_pkg::MaxEvents))
    else $error("too many events in one tick");
  a_stable_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i && stable_d != stable_q) |-> (lvl_d == '0 || lvl_d == LvlMax))
    else $error("stable level changed away from debounce limits");

endmodule

// ===== src/bdpd_fifo.sv =====
// Short queue of event bundles between front and back.
// Depends on bdpd_pkg.
module bdpd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bdpd_pkg::bundle_t bundle_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output bdpd_pkg::bundle_t head_o
);

  localparam int unsigned PtrW = $clog2(bdpd_pkg::FifoDepth);
  localparam int unsigned CntW = $clog2(bdpd_pkg::FifoDepth + 1);

  bdpd_pkg::bundle_t mem_q [bdpd_pkg::FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(bdpd_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(bdpd_pkg::FifoDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(bdpd_pkg::FifoDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (!push_i && pop_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count did not grow");

endmodule

// ===== src/bdpd_back.sv =====
// Back end: walks the queued bundle one event per cycle into the output register
// while ready_i does not stall it. Depends on bdpd_pkg.
module bdpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  bdpd_pkg::bundle_t head_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [2:0]        event_kind_o,
  output logic [7:0]        press_total_o,
  output logic              last_event_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [2:0] kind_q;
  logic [7:0] total_q;
  logic       last_q;
  logic       load, is_last;
  bdpd_pkg::evt_kind_e cur;

  assign cur     = head_i.kind[idx_q];
  assign is_last = ({1'b0, idx_q} == head_i.num - 3'd1);
  assign load    = !empty_i && (!valid_q || ready_i);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= cur;
      total_q <= (cur == bdpd_pkg::EV_PRESS_COUNT) ? head_i.total : 8'd0;
      last_q  <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign valid_o       = valid_q;
  assign event_kind_o  = kind_q;
  assign press_total_o = total_q;
  assign last_event_o  = last_q;

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> ({1'b0, idx_q} < head_i.num))
    else $error("event index beyond bundle");
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (valid_q && last_q && idx_q == 2'd0))
    else $error("pop without last event loaded");

endmodule

// ===== src/button_debounce_press_detector.sv =====
// Top level of the button debounce and press detector.
// Depends on bdpd_pkg, bdpd_if, bdpd_front, bdpd_fifo, bdpd_back.
//
//  channel   dir  payload                                  transfer when
//  tick_i    in   pin_level                                valid && ready
//  event_o   out  event_kind, press_total, last_event      valid && ready
//  cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i          cfg_we_i high
//
// One tick is taken per cycle while the two-entry bundle queue has room and no
// register write is under way.
// A tick yields 0..4 events; the back end emits one event per cycle while
// event_o does not stall; each passes a queue entry, then the output register.
// Ticks without events take no queue entry but still wait while the queue is
// full. Reset is async, active low, and loads the register defaults; stalls on
// event_o fill the queue, then drop tick_i.ready.
module button_debounce_press_detector #(
  parameter int unsigned DEBOUNCE_LIMIT = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  bdpd_tick_if.sink    tick_i,
  bdpd_event_if.source event_o
);

  logic              push, pop, full, empty;
  bdpd_pkg::bundle_t bundle, head;

  bdpd_front #(
    .DEBOUNCE_LIMIT(DEBOUNCE_LIMIT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .tick_valid_i (tick_i.valid),
    .pin_level_i  (tick_i.pin_level),
    .full_i       (full),
    .tick_ready_o (tick_i.ready),
    .push_o       (push),
    .bundle_o     (bundle)
  );

  bdpd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .pop_i    (pop),
    .full_o   (full),
    .empty_o  (empty),
    .head_o   (head)
  );

  bdpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .valid_o       (event_o.valid),
    .ready_i       (event_o.ready),
    .event_kind_o  (event_o.event_kind),
    .press_total_o (event_o.press_total),
    .last_event_o  (event_o.last_event)
  );

endmodule
